FILE: design/multidim_bin_index_assert.svh
// assertion macros shared by the multidim bin index design files
`ifndef MULTIDIM_BIN_INDEX_ASSERT_SVH
`define MULTIDIM_BIN_INDEX_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define MBI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define MBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mbi_pkg.sv
// types, constants and helpers for the multidim bin index block
package mbi_pkg;

  localparam int NUM_AXES_DEF  = 4;
  localparam int MAX_EDGES_DEF = 32;
  localparam int COORD_FIELDS  = 4;
  localparam int EDGE_W        = 32;
  localparam int CNT_W         = 6;
  localparam int AXES_W        = 3;
  localparam int BIN_W         = 20;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXES_IN_USE = 3'd0,
    REG_EDGES_AXIS0 = 3'd1,
    REG_EDGES_AXIS1 = 3'd2,
    REG_EDGES_AXIS2 = 3'd3,
    REG_EDGES_AXIS3 = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD_EDGE = 1'b0,
    OP_FIND_BIN  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LO,
    S_HI,
    S_PROBE,
    S_MAC,
    S_RAD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic               op;
    logic [1:0]         edge_axis;
    logic [4:0]         edge_slot;
    logic signed [31:0] edge_value;
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
    logic signed [31:0] coord_3;
  } in_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic             in_range;
  } out_t;

  function automatic logic signed [EDGE_W-1:0] coord_sel(in_t item, logic [1:0] ax);
    logic signed [EDGE_W-1:0] c;
    unique case (ax)
      2'd0: c = item.coord_0;
      2'd1: c = item.coord_1;
      2'd2: c = item.coord_2;
      2'd3: c = item.coord_3;
      default: c = item.coord_0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/multidim_bin_index.sv
// multidim bin index: per-axis binary search over stored edges, mixed-radix bin number
//
// A load transaction (op 0) writes one signed Q16.16 bin edge into the edge table at
// (edge_axis, edge_slot) and produces no result. Slots or axes beyond the
// table are dropped. A find transaction (op 1) carries one coordinate per axis; for each of
// the axes in use the block locates the last edge not above the coordinate and folds the
// positions into one bin number, axis 0 least significant, radix edges-1 per axis. A
// coordinate on the last edge lands in the last bin; one outside the first/last edge gives
// bin_index 0 with in_range 0. With no axes in use the result is bin 0, in range.
// Edges must be loaded before they are searched: unwritten entries read as garbage.
// Sequencing: the edge table has one write port and one registered read port, so the
// sequencer reads at most one edge per cycle and a single comparator checks it. Per axis
// it checks the first edge, then the last, then searches with at most ceil(log2(n+1))
// probes (n the edge count) and folds the position into the bin number; a search ends
// early on an exact hit, and a find stops at a coordinate outside its range. The input
// is stalled while a find transaction is in flight; the result sits in an output register,
// so a new transaction is taken while an earlier result still waits downstream.
// Configuration (cfg_index: 0 axes_in_use, 1..4 edge counts) is always ready and must only
// be written while the block is idle.
module multidim_bin_index
  import mbi_pkg::*;
#(
  parameter int NUM_AXES  = NUM_AXES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // result transactions
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "multidim_bin_index_assert.svh"

  // table geometry
  localparam int DEPTH  = NUM_AXES * MAX_EDGES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // largest usable edge count: bounded by the table and by the count register width
  localparam int MAX_N  = (MAX_EDGES < 63) ? MAX_EDGES : 63;
  // search bounds run 0 .. n+1
  localparam int BND_W  = $clog2(MAX_N + 2);
  // a bin position runs 0 .. n-2
  localparam int POS_W  = (MAX_N > 2) ? $clog2(MAX_N - 1) : 1;
  localparam int AX_LIM = (NUM_AXES < COORD_FIELDS) ? NUM_AXES : COORD_FIELDS;

  // configuration registers
  logic [AXES_W-1:0] axes_in_use_r;
  logic [CNT_W-1:0]  count_r [COORD_FIELDS];

  // sequencer and datapath registers
  state_t            state_r, state_nxt;
  in_t               item_r, item_nxt;
  logic [AXES_W-1:0] axes_r, axes_nxt;
  logic [AXES_W-1:0] axis_r, axis_nxt;
  logic [BND_W-1:0]  above_r, above_nxt;
  logic [BND_W-1:0]  below_r, below_nxt;
  logic [BND_W-1:0]  mid_r, mid_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [BIN_W-1:0]  radix_r, radix_nxt;
  logic              ok_r, ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  // memory ports
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [EDGE_W-1:0] rd_data;

  // shared compare unit and probe step
  logic                     in_fire;
  logic [AXES_W-1:0]        axes_eff;
  logic [CNT_W-1:0]         n_cur;
  logic signed [EDGE_W-1:0] key;
  logic                     cmp_eq, cmp_lt;
  logic [BND_W-1:0]         above_p, below_p;
  logic                     search_done;
  logic [BND_W-1:0]         raw_pos;
  logic [BND_W-1:0]         pos_lim;
  logic [POS_W-1:0]         pos_clamped;
  logic [BND_W:0]           mid_sum;
  logic [BND_W-1:0]         mid_p;
  logic [BND_W-1:0]         n_plus1;
  logic [BND_W:0]           init_sum;
  logic                     out_free;

  // shared multiplier
  logic [CNT_W-1:0]         mul_b;
  logic [BIN_W+CNT_W-1:0]   mul_full;
  logic [BIN_W-1:0]         mul_p;

  function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c < CNT_W'(2)) begin
      r = CNT_W'(2);
    end else if (c > CNT_W'(MAX_N)) begin
      r = CNT_W'(MAX_N);
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] edge_addr(logic [1:0] ax, logic [BND_W-1:0] slot);
    return AW'(ax) * AW'(MAX_EDGES) + AW'(slot);
  endfunction

  mbi_edge_ram #(
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.edge_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // configuration port, never busy
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axes_in_use_r <= '0;
      for (int i = 0; i < COORD_FIELDS; i++) begin
        count_r[i] <= CNT_W'(2);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AXES_IN_USE: axes_in_use_r <= cfg_data[AXES_W-1:0];
        REG_EDGES_AXIS0: count_r[0]    <= cfg_data[CNT_W-1:0];
        REG_EDGES_AXIS1: count_r[1]    <= cfg_data[CNT_W-1:0];
        REG_EDGES_AXIS2: count_r[2]    <= cfg_data[CNT_W-1:0];
        REG_EDGES_AXIS3: count_r[3]    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // edge load goes straight to the table when in range of it
  assign wr_en   = in_fire && (in_data.op == OP_LOAD_EDGE) &&
                   (int'(in_data.edge_axis) < NUM_AXES) &&
                   (int'(in_data.edge_slot) < MAX_EDGES);
  assign wr_addr = AW'(in_data.edge_axis) * AW'(MAX_EDGES) + AW'(in_data.edge_slot);

  // axes in use, saturated to what the block carries
  always_comb begin
    axes_eff = axes_in_use_r;
    if (axes_eff > AXES_W'(AX_LIM)) begin
      axes_eff = AXES_W'(AX_LIM);
    end
  end

  // per-axis operands
  assign n_cur = clamp_cnt(count_r[axis_r[1:0]]);
  assign key   = coord_sel(item_r, axis_r[1:0]);

  // single comparator, signed order
  assign cmp_eq = (key == rd_data);
  assign cmp_lt = (key < rd_data);

  // one halving step
  assign above_p     = (!cmp_eq && cmp_lt)  ? mid_r : above_r;
  assign below_p     = (!cmp_eq && !cmp_lt) ? mid_r : below_r;
  assign search_done = cmp_eq || ((above_p - below_p) <= BND_W'(1));
  assign mid_sum     = {1'b0, above_p} + {1'b0, below_p};
  assign mid_p       = mid_sum[BND_W:1];

  // position of the last edge not above the key, kept to 0 .. n-2
  always_comb begin
    if (cmp_eq) begin
      raw_pos = mid_r - BND_W'(1);
    end else if (below_p == '0) begin
      raw_pos = '0;
    end else begin
      raw_pos = below_p - BND_W'(1);
    end
    pos_lim = BND_W'(n_cur) - BND_W'(2);
    if (raw_pos > pos_lim) begin
      pos_clamped = POS_W'(pos_lim);
    end else begin
      pos_clamped = POS_W'(raw_pos);
    end
  end

  // first probe: bounds 0 and n+1
  assign n_plus1  = BND_W'(n_cur) + BND_W'(1);
  assign init_sum = {1'b0, n_plus1};

  // shared multiplier: position times radix, then radix times edges-1
  assign mul_b    = (state_r == S_MAC) ? CNT_W'(pos_r) : (n_cur - CNT_W'(1));
  assign mul_full = radix_r * mul_b;
  assign mul_p    = mul_full[BIN_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.op == OP_FIND_BIN)) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = (axes_r == '0) ? S_FIN : S_LO;
      end
      S_LO: begin
        state_nxt = cmp_lt ? S_FIN : S_HI;
      end
      S_HI: begin
        state_nxt = (!cmp_lt && !cmp_eq) ? S_FIN : S_PROBE;
      end
      S_PROBE: begin
        if (search_done) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        state_nxt = S_RAD;
      end
      S_RAD: begin
        state_nxt = ((axis_r + AXES_W'(1)) == axes_r) ? S_FIN : S_LO;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory read control
  always_comb begin
    item_nxt      = item_r;
    axes_nxt      = axes_r;
    axis_nxt      = axis_r;
    above_nxt     = above_r;
    below_nxt     = below_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    bin_nxt       = bin_r;
    radix_nxt     = radix_r;
    ok_nxt        = ok_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = edge_addr(axis_r[1:0], '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt  = in_data;
          axes_nxt  = axes_eff;
          axis_nxt  = '0;
          bin_nxt   = '0;
          radix_nxt = BIN_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      S_START: begin
        // fetch the first edge of axis 0
        rd_en = 1'b1;
      end
      S_LO: begin
        if (cmp_lt) begin
          ok_nxt = 1'b0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = edge_addr(axis_r[1:0], BND_W'(n_cur) - BND_W'(1));
        end
      end
      S_HI: begin
        if (!cmp_lt && !cmp_eq) begin
          ok_nxt = 1'b0;
        end else begin
          above_nxt = n_plus1;
          below_nxt = '0;
          mid_nxt   = init_sum[BND_W:1];
          rd_en     = 1'b1;
          rd_addr   = edge_addr(axis_r[1:0], init_sum[BND_W:1] - BND_W'(1));
        end
      end
      S_PROBE: begin
        above_nxt = above_p;
        below_nxt = below_p;
        if (search_done) begin
          pos_nxt = pos_clamped;
        end else begin
          mid_nxt = mid_p;
          rd_en   = 1'b1;
          rd_addr = edge_addr(axis_r[1:0], mid_p - BND_W'(1));
        end
      end
      S_MAC: begin
        bin_nxt = bin_r + mul_p;
      end
      S_RAD: begin
        radix_nxt = mul_p;
        axis_nxt  = axis_r + AXES_W'(1);
        // fetch the first edge of the next axis
        rd_en   = 1'b1;
        rd_addr = edge_addr(axis_nxt[1:0], '0);
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.in_range  = ok_r;
          out_data_nxt.bin_index = ok_r ? bin_r : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    axes_r     <= axes_nxt;
    axis_r     <= axis_nxt;
    above_r    <= above_nxt;
    below_r    <= below_nxt;
    mid_r      <= mid_nxt;
    pos_r      <= pos_nxt;
    bin_r      <= bin_nxt;
    radix_r    <= radix_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
  end

  // a find transaction always starts the sequencer
  `MBI_ASSERT_NEXT(a_find_starts, in_fire && (in_data.op == OP_FIND_BIN), state_r == S_START, "find transaction did not start the sequencer")

  // probed edge lies strictly inside the open search interval
  `MBI_ASSERT_NOW(a_mid_inside, state_r == S_PROBE, (mid_r > below_r) && (mid_r < above_r), "probe midpoint outside search bounds")

  // working axis stays below the number of axes in use
  `MBI_ASSERT_NOW(a_axis_bound, (state_r == S_LO) || (state_r == S_HI) || (state_r == S_PROBE) || (state_r == S_MAC) || (state_r == S_RAD), axis_r < axes_r, "axis counter past axes in use")

  // an out-of-range result carries bin zero
  `MBI_ASSERT_NOW(a_oor_zero, out_valid_r && !out_data_r.in_range, out_data_r.bin_index == '0, "out-of-range result with nonzero bin")

  // a new result only comes from the finish step
  `MBI_ASSERT_NOW(a_result_src, $rose(out_valid_r), $past(state_r) == S_FIN, "result raised outside finish step")

endmodule

FILE: design/mbi_edge_ram.sv
// edge table memory: one write port, one registered read port
module mbi_edge_ram
  import mbi_pkg::*;
#(
  parameter int DEPTH = NUM_AXES_DEF * MAX_EDGES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [EDGE_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [EDGE_W-1:0] rd_data
);

  logic signed [EDGE_W-1:0] mem [DEPTH];
  logic signed [EDGE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
